/* hw/rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// assertion helpers shared by the rtl
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on the rising edge of i_clk
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, checked on the rising edge of i_clk
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* hw/rtl/dxt5_pkg.sv */
// ---------------------------------------------------------------------------
// dxt5_pkg
// types, constants and palette helpers for the dxt5 block decoder
// ---------------------------------------------------------------------------
package dxt5_pkg;

    // configuration register indexes
    localparam logic CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic CFG_IMAGE_HEIGHT = 1'b1;

    localparam int          CFG_W         = 13;
    localparam logic [12:0] EXTENT_RESET  = 13'd4096;
    localparam int          DEF_MAX_EXTENT = 4096;

    // reciprocals for truncating divides (scaled by 2^15, rounded up)
    localparam logic [23:0] RECIP_7 = 24'd4682;
    localparam logic [23:0] RECIP_5 = 24'd6554;
    localparam logic [23:0] RECIP_3 = 24'd10923;

    typedef logic [7:0][7:0]  t_apal;   // eight alpha entries
    typedef logic [3:0][23:0] t_cpal;   // four rgb888 entries

    // x / 7 for x up to 1785
    function automatic logic [7:0] div7(input logic [10:0] x);
        logic [23:0] p;
        p = 24'(x) * RECIP_7;
        return p[22:15];
    endfunction

    // x / 5 for x up to 1275
    function automatic logic [7:0] div5(input logic [10:0] x);
        logic [23:0] p;
        p = 24'(x) * RECIP_5;
        return p[22:15];
    endfunction

    // x / 3 for x up to 765
    function automatic logic [7:0] div3(input logic [9:0] x);
        logic [23:0] p;
        p = 24'(x) * RECIP_3;
        return p[22:15];
    endfunction

    // alpha palette, six-step or four-step mode by endpoint order
    function automatic t_apal alpha_palette(input logic [7:0] a0, input logic [7:0] a1);
        t_apal pal;
        pal    = '0;
        pal[0] = a0;
        pal[1] = a1;
        if (a0 > a1) begin
            for (int i = 1; i <= 6; i++) begin
                pal[i + 1] = div7(11'(a0) * 11'(7 - i) + 11'(a1) * 11'(i));
            end
        end else begin
            for (int i = 1; i <= 4; i++) begin
                pal[i + 1] = div5(11'(a0) * 11'(5 - i) + 11'(a1) * 11'(i));
            end
            pal[6] = 8'd0;
            pal[7] = 8'd255;
        end
        return pal;
    endfunction

    // rgb565 to rgb888 by bit replication
    function automatic logic [23:0] expand565(input logic [15:0] c);
        logic [4:0] r;
        logic [5:0] g;
        logic [4:0] b;
        r = c[15:11];
        g = c[10:5];
        b = c[4:0];
        return {r, r[4:2], g, g[5:4], b, b[4:2]};
    endfunction

    // four-color palette with truncating thirds
    function automatic t_cpal color_palette(input logic [15:0] c0, input logic [15:0] c1);
        t_cpal       pal;
        logic [23:0] e0;
        logic [23:0] e1;
        e0     = expand565(c0);
        e1     = expand565(c1);
        pal    = '0;
        pal[0] = e0;
        pal[1] = e1;
        for (int ch = 0; ch < 3; ch++) begin
            pal[2][ch*8 +: 8] = div3({1'b0, e0[ch*8 +: 8], 1'b0} + 10'(e1[ch*8 +: 8]));
            pal[3][ch*8 +: 8] = div3(10'(e0[ch*8 +: 8]) + {1'b0, e1[ch*8 +: 8], 1'b0});
        end
        return pal;
    endfunction

    // index of the single set bit of a one-hot pixel mask
    function automatic logic [3:0] encode16(input logic [15:0] oh);
        logic [3:0] idx;
        idx = '0;
        for (int i = 0; i < 16; i++) begin
            if (oh[i]) begin
                idx = idx | 4'(i);
            end
        end
        return idx;
    endfunction

endpackage

/* hw/rtl/dxt5_block_decoder_top.sv */
// ---------------------------------------------------------------------------
// dxt5_block_decoder_top
// bc3 / dxt5 block decoder: one compressed 4x4 block in, argb pixels out
// ---------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_stall carry one compressed block word
// (alpha and color endpoints, index codes, tile column and row). Output
// channel: o_out_valid / i_out_stall carry one decoded pixel word per
// cycle while not stalled, in raster order, pixels at or beyond the image
// size skipped, with o_last_pixel set on the final pixel of the block. A
// block with no pixel inside the image produces no output word.
// A block word moves from the input register to the emit stage, and each
// pixel is registered in the output register. Throughput: one pixel per
// cycle while the receiver does not stall; a clipped block yields only its
// visible pixels. The pixel emit stage sets this rate; the next block
// waits in the input register meanwhile.
// Image size is set by the write port (index 0 width, index 1 height);
// write it only while the decoder is empty. Reset (synchronous, active
// low) empties all stages and sets both sizes to 4096. While the receiver
// stalls, the pixel on the output holds and the decoder fills up, then
// stalls the input.
// ---------------------------------------------------------------------------
module dxt5_block_decoder_top #(
    parameter int MAX_EXTENT = dxt5_pkg::DEF_MAX_EXTENT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration write port
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_index,
    input  logic [dxt5_pkg::CFG_W-1:0]  i_cfg_data,
    // block input channel
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [7:0]                  i_alpha_end0,
    input  logic [7:0]                  i_alpha_end1,
    input  logic [47:0]                 i_alpha_codes,
    input  logic [15:0]                 i_color_end0,
    input  logic [15:0]                 i_color_end1,
    input  logic [31:0]                 i_color_codes,
    input  logic [9:0]                  i_tile_col,
    input  logic [9:0]                  i_tile_row,
    // pixel output channel
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [11:0]                 o_pixel_x,
    output logic [11:0]                 o_pixel_y,
    output logic [31:0]                 o_argb,
    output logic                        o_last_pixel
);
    import dxt5_pkg::*;

    `include "assert_macros.svh"

    localparam int EXT_W = $clog2(MAX_EXTENT + 1);
    localparam int CMP_W = (EXT_W > CFG_W) ? EXT_W : CFG_W;

    // configuration registers
    logic [CFG_W-1:0] r_width;
    logic [CFG_W-1:0] r_height;

    // input stage
    logic        r_a_vld;
    logic [7:0]  r_a_a0;
    logic [7:0]  r_a_a1;
    logic [47:0] r_a_acodes;
    logic [15:0] r_a_c0;
    logic [15:0] r_a_c1;
    logic [31:0] r_a_ccodes;
    logic [9:0]  r_a_col;
    logic [9:0]  r_a_row;

    // emit stage
    logic [15:0] r_b_mask;
    logic [15:0] n_b_mask;
    t_apal       r_b_apal;
    t_cpal       r_b_cpal;
    logic [47:0] r_b_acodes;
    logic [31:0] r_b_ccodes;
    logic [9:0]  r_b_col;
    logic [9:0]  r_b_row;

    // output stage
    logic        r_o_vld;
    logic [11:0] r_o_x;
    logic [11:0] r_o_y;
    logic [31:0] r_o_argb;
    logic        r_o_last;

    logic        o_free;
    logic        emit;
    logic        b_free;
    logic        a_to_b;
    logic        a_take;
    logic [15:0] sel_oh;
    logic [15:0] rest;
    logic [3:0]  sel_idx;
    logic [2:0]  sel_ai;
    logic [1:0]  sel_ci;
    logic [CMP_W-1:0] w_lim;
    logic [CMP_W-1:0] h_lim;
    logic [3:0]  col_in;
    logic [3:0]  row_in;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= EXTENT_RESET;
            r_height <= EXTENT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_IMAGE_WIDTH:  r_width  <= i_cfg_data;
                CFG_IMAGE_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // handshake and stage movement
    assign o_free     = !r_o_vld || !i_out_stall;
    assign emit       = (r_b_mask != '0) && o_free;
    assign sel_oh     = r_b_mask & (~r_b_mask + 16'd1);
    assign rest       = r_b_mask & ~sel_oh;
    assign b_free     = (r_b_mask == '0) || (emit && (rest == '0));
    assign a_to_b     = r_a_vld && b_free;
    assign a_take     = i_in_valid && (!r_a_vld || a_to_b);
    assign o_in_stall = r_a_vld && !a_to_b;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (a_take) begin
            r_a_vld <= 1'b1;
        end else if (a_to_b) begin
            r_a_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_take) begin
            r_a_a0     <= i_alpha_end0;
            r_a_a1     <= i_alpha_end1;
            r_a_acodes <= i_alpha_codes;
            r_a_c0     <= i_color_end0;
            r_a_c1     <= i_color_end1;
            r_a_ccodes <= i_color_codes;
            r_a_col    <= i_tile_col;
            r_a_row    <= i_tile_row;
        end
    end

    // image size limits, clamped to the supported extent
    always_comb begin
        w_lim = CMP_W'(r_width);
        h_lim = CMP_W'(r_height);
        if (w_lim > CMP_W'(MAX_EXTENT)) begin
            w_lim = CMP_W'(MAX_EXTENT);
        end
        if (h_lim > CMP_W'(MAX_EXTENT)) begin
            h_lim = CMP_W'(MAX_EXTENT);
        end
    end

    // visible columns and rows of the incoming block
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            col_in[k] = CMP_W'({r_a_col, 2'(k)}) < w_lim;
            row_in[k] = CMP_W'({r_a_row, 2'(k)}) < h_lim;
        end
    end

    // next pixel mask: load a new block or retire the emitted pixel
    always_comb begin
        n_b_mask = r_b_mask;
        if (a_to_b) begin
            for (int p = 0; p < 16; p++) begin
                n_b_mask[p] = col_in[p % 4] && row_in[p / 4];
            end
        end else if (emit) begin
            n_b_mask = rest;
        end
    end

    // emit stage: decoded palettes and pending pixel mask
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_mask <= '0;
        end else begin
            r_b_mask <= n_b_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_to_b) begin
            r_b_apal   <= alpha_palette(r_a_a0, r_a_a1);
            r_b_cpal   <= color_palette(r_a_c0, r_a_c1);
            r_b_acodes <= r_a_acodes;
            r_b_ccodes <= r_a_ccodes;
            r_b_col    <= r_a_col;
            r_b_row    <= r_a_row;
        end
    end

    // lowest pending pixel and its palette indexes
    assign sel_idx = encode16(sel_oh);
    assign sel_ai  = r_b_acodes[3*sel_idx +: 3];
    assign sel_ci  = r_b_ccodes[2*sel_idx +: 2];

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (o_free) begin
            r_o_vld <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_o_x    <= {r_b_col, sel_idx[1:0]};
            r_o_y    <= {r_b_row, sel_idx[3:2]};
            r_o_argb <= {r_b_apal[sel_ai], r_b_cpal[sel_ci]};
            r_o_last <= (rest == '0);
        end
    end

    assign o_out_valid  = r_o_vld;
    assign o_pixel_x    = r_o_x;
    assign o_pixel_y    = r_o_y;
    assign o_argb       = r_o_argb;
    assign o_last_pixel = r_o_last;

    // checks
    `ASSERT_NEXT(a_emit_loads_out, emit, r_o_vld && (r_o_x[1:0] == $past(sel_idx[1:0])))
    `ASSERT_NEXT(a_stall_holds_mask, r_o_vld && i_out_stall && (r_b_mask != '0),
                 $stable(r_b_mask))
    `ASSERT_SAME(a_empty_no_stall, !r_a_vld, !o_in_stall)
    `ASSERT_SAME(a_last_ends_block, emit && (rest == '0) && r_a_vld, a_to_b)

endmodule
